>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while reset is asserted (active-low)
`define SVDP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// concurrent check, also evaluated during reset
`define SVDP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/svdp_pkg.sv
`timescale 1ns / 1ps

package svdp_pkg;

    localparam int MAX_LENGTH_DEF = 256;
    localparam int VALUE_W        = 16;
    localparam int PROD_W         = 32;
    localparam int DOT_W          = 40;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic active;
        logic last;
        logic emit;
        logic truncated;
    } svdp_ctl_t;

endpackage

>>> hw/rtl/svdp_ram.sv
`timescale 1ns / 1ps

module svdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/svdp_mac.sv
`timescale 1ns / 1ps

module svdp_mac #(
    parameter int TERMS_W = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  svdp_pkg::svdp_ctl_t               in_ctl,
    input  logic signed [svdp_pkg::VALUE_W-1:0] in_value,
    input  logic signed [svdp_pkg::VALUE_W-1:0] in_ref,
    input  logic [TERMS_W-1:0]                in_terms,
    output logic                              out_valid,
    output logic signed [svdp_pkg::DOT_W-1:0] out_dot,
    output logic [TERMS_W-1:0]                out_terms,
    output logic                              out_truncated
);

    import svdp_pkg::*;

    localparam logic signed [DOT_W-1:0] ACC_MAX = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic signed [DOT_W-1:0] ACC_MIN = {1'b1, {(DOT_W-1){1'b0}}};

    logic                      s2_valid_reg;
    svdp_ctl_t                 s2_ctl_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg;
    logic signed [PROD_W-1:0]  s2_prod_next;
    logic [TERMS_W-1:0]        s2_terms_reg;

    logic signed [DOT_W-1:0]   acc_reg;
    logic signed [DOT_W:0]     sum_wide;
    logic signed [DOT_W-1:0]   sum_sat;

    logic                      out_valid_reg;
    logic signed [DOT_W-1:0]   out_dot_reg;
    logic [TERMS_W-1:0]        out_terms_reg;
    logic                      out_truncated_reg;

    always_comb begin
        s2_prod_next = '0;
        if (in_valid && in_ctl.active) begin
            s2_prod_next = in_value * in_ref;
        end
        sum_wide = (DOT_W+1)'(acc_reg) + (DOT_W+1)'(s2_prod_reg);
        sum_sat  = sum_wide[DOT_W-1:0];
        if (sum_wide[DOT_W] != sum_wide[DOT_W-1]) begin
            sum_sat = sum_wide[DOT_W] ? ACC_MIN : ACC_MAX;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            s2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg  <= in_valid;
            out_valid_reg <= s2_valid_reg && s2_ctl_reg.emit;
            if (s2_valid_reg) begin
                acc_reg <= s2_ctl_reg.last ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            s2_ctl_reg   <= in_ctl;
            s2_prod_reg  <= s2_prod_next;
            s2_terms_reg <= in_terms;
            if (s2_valid_reg && s2_ctl_reg.emit) begin
                out_dot_reg       <= sum_sat;
                out_terms_reg     <= s2_terms_reg;
                out_truncated_reg <= s2_ctl_reg.truncated;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_dot       = out_dot_reg;
    assign out_terms     = out_terms_reg;
    assign out_truncated = out_truncated_reg;

endmodule

>>> hw/rtl/stored_vector_dot_product_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Dot product of streamed query vectors with a stored reference vector of up to
// MAX_LENGTH signed Q8.8 elements. Requests with tuser = 0 load the next reference
// element (tlast ends the load and sets the length); requests with tuser = 1 are
// query elements, multiplied with the reference element at the same position and
// summed while the position is below the stored length. A query request with tlast
// produces one result (saturated Q24.16 sum, term count, truncation flag) unless
// the stored length is zero. One request is accepted every cycle while s_tready is
// high; a result reaches the output register through the registered reference RAM
// read, the product register and the accumulate/output register. The pipeline
// advances only while the output register is empty or being taken, so s_tready
// follows m_tready whenever a result is pending.

module stored_vector_dot_product_core #(
    parameter int MAX_LENGTH = svdp_pkg::MAX_LENGTH_DEF,
    localparam int LEN_W = $clog2(MAX_LENGTH + 1),
    localparam int OUT_W = ((svdp_pkg::DOT_W + LEN_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [svdp_pkg::VALUE_W-1:0]  s_tdata,   // [15:0] value
    input  logic                          s_tuser,   // [0] operation
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,   // [39:0] dot, then terms
    output logic                          m_tuser    // [0] truncated
);

    import svdp_pkg::*;

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LENGTH);

    logic                      adv;
    logic                      accept;
    logic                      is_load;
    logic                      is_query;
    logic                      ld_room;
    logic                      q_active;
    logic [LEN_W-1:0]          qpos_inc;

    logic [LEN_W-1:0]          ref_len_reg, ref_len_next;
    logic [LEN_W-1:0]          lpos_reg, lpos_next;
    logic [LEN_W-1:0]          qpos_reg, qpos_next;
    logic                      ovf_reg, ovf_next;

    logic                      s1_valid_reg;
    svdp_ctl_t                 s1_ctl_reg, s1_ctl_next;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic [LEN_W-1:0]          s1_terms_reg;
    logic signed [VALUE_W-1:0] ref_data;

    logic                      res_valid;
    logic signed [DOT_W-1:0]   res_dot;
    logic [LEN_W-1:0]          res_terms;
    logic                      res_truncated;

    assign adv      = !res_valid || m_tready;
    assign s_tready = adv;

    always_comb begin
        accept   = s_tvalid && s_tready;
        is_load  = accept && (op_t'(s_tuser) == OP_LOAD);
        is_query = accept && (op_t'(s_tuser) == OP_QUERY);
        ld_room  = lpos_reg < MAX_LEN;
        q_active = qpos_reg < ref_len_reg;
        qpos_inc = q_active ? qpos_reg + 1'b1 : qpos_reg;

        lpos_next    = lpos_reg;
        ref_len_next = ref_len_reg;
        ovf_next     = ovf_reg;
        qpos_next    = qpos_reg;

        if (is_load) begin
            if (lpos_reg == '0) begin
                ovf_next = 1'b0;
            end
            if (ld_room) begin
                lpos_next = lpos_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
            if (s_tlast) begin
                ref_len_next = lpos_next;
                lpos_next    = '0;
            end
        end

        if (is_query) begin
            qpos_next = s_tlast ? '0 : qpos_inc;
        end

        s1_ctl_next.active    = is_query && q_active;
        s1_ctl_next.last      = is_query && s_tlast;
        s1_ctl_next.emit      = is_query && s_tlast && (ref_len_reg != '0);
        s1_ctl_next.truncated = ovf_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_len_reg  <= '0;
            lpos_reg     <= '0;
            qpos_reg     <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            ref_len_reg <= ref_len_next;
            lpos_reg    <= lpos_next;
            qpos_reg    <= qpos_next;
            ovf_reg     <= ovf_next;
            if (adv) begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctl_reg   <= s1_ctl_next;
            s1_value_reg <= s_tdata;
            s1_terms_reg <= qpos_inc;
        end
    end

    svdp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_LENGTH)
    ) u_ref_ram (
        .clk   (aclk),
        .we    (is_load && ld_room),
        .waddr (lpos_reg[AW-1:0]),
        .wdata (s_tdata),
        .re    (adv),
        .raddr (qpos_reg[AW-1:0]),
        .rdata (ref_data)
    );

    svdp_mac #(
        .TERMS_W (LEN_W)
    ) u_mac (
        .clk           (aclk),
        .rst_n         (aresetn),
        .adv           (adv),
        .in_valid      (s1_valid_reg),
        .in_ctl        (s1_ctl_reg),
        .in_value      (s1_value_reg),
        .in_ref        (ref_data),
        .in_terms      (s1_terms_reg),
        .out_valid     (res_valid),
        .out_dot       (res_dot),
        .out_terms     (res_terms),
        .out_truncated (res_truncated)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = OUT_W'({res_terms, res_dot});
    assign m_tuser  = res_truncated;

    `SVDP_ASSERT(a_len_bound, aclk, aresetn, ref_len_reg <= MAX_LEN, "stored length past max")
    `SVDP_ASSERT(a_lpos_bound, aclk, aresetn, lpos_reg <= MAX_LEN, "load position past max")
    `SVDP_ASSERT(a_query_clear, aclk, aresetn, is_query && s_tlast |=> qpos_reg == '0, "query position not cleared")
    `SVDP_ASSERT(a_stall_hold, aclk, aresetn, res_valid && !m_tready |=> s1_valid_reg == $past(s1_valid_reg), "pipeline moved during stall")

endmodule

>>> tb/tb_stored_vector_dot_product_core.sv
`timescale 1ns / 1ps

module tb_stored_vector_dot_product_core;
    import svdp_pkg::*;

    localparam int     MAX_LEN        = MAX_LENGTH_DEF;
    localparam int     RANDOM_REQS    = 500;
    localparam int     HOLD_CYCLES    = 200;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     DRAIN_CYCLES   = 16;
    localparam longint DOT_MAX        = 64'sd549755813887;
    localparam longint DOT_MIN        = -64'sd549755813888;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [8:0]              terms;
        logic                    truncated;
    } dot_result_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] value;
        logic        last;
        logic [8:0]  reps;
        logic        given;
        dot_result_t result;
    } dir_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = OP_LOAD;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    // reference state
    logic [15:0] ref_mem [MAX_LEN];
    int unsigned ref_len;
    int unsigned load_pos;
    int unsigned query_pos;
    longint      dot_acc;
    logic        trunc_mark;

    dot_result_t expected_dots [$];
    int          mismatches;
    int          sent_requests;
    bit          hold_wanted;
    bit          hold_done;
    bit          src_burst;
    bit          sink_burst;

    localparam int DIR_ROWS = 27;
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{OP_QUERY, 16'h1234, 1'b1, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_LOAD,  16'h7FFF, 1'b0, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_LOAD,  16'h8000, 1'b1, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h7FFF, 1'b0, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h8000, 1'b1, 9'd1,   1'b1, '{40'sd2147418113, 9'd2, 1'b0}},
        '{OP_QUERY, 16'h8000, 1'b0, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h7FFF, 1'b1, 9'd1,   1'b1, '{-40'sd2147418112, 9'd2, 1'b0}},
        // query longer than reference
        '{OP_QUERY, 16'h0100, 1'b0, 9'd2,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h0100, 1'b1, 9'd1,   1'b1, '{-40'sd256, 9'd2, 1'b0}},
        '{OP_QUERY, 16'h0001, 1'b1, 9'd1,   1'b1, '{40'sd32767, 9'd1, 1'b0}},
        // query while a load is half done
        '{OP_LOAD,  16'h0002, 1'b0, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h0003, 1'b0, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h0001, 1'b1, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_LOAD,  16'hFFFF, 1'b1, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        // full length, largest magnitudes
        '{OP_LOAD,  16'h8000, 1'b0, 9'd255, 1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_LOAD,  16'h8000, 1'b1, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h8000, 1'b0, 9'd255, 1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h8000, 1'b1, 9'd1,   1'b1, '{40'sd274877906944, 9'd256, 1'b0}},
        '{OP_QUERY, 16'h7FFF, 1'b0, 9'd255, 1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h7FFF, 1'b1, 9'd1,   1'b1, '{-40'sd274869518336, 9'd256, 1'b0}},
        // too long load, query sees the mark while the load is still open
        '{OP_LOAD,  16'h0100, 1'b0, 9'd257, 1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h0100, 1'b1, 9'd1,   1'b1, '{40'sd65536, 9'd1, 1'b1}},
        '{OP_LOAD,  16'h0100, 1'b1, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h0100, 1'b0, 9'd256, 1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h0100, 1'b1, 9'd1,   1'b1, '{40'sd16777216, 9'd256, 1'b1}},
        // new load clears the mark
        '{OP_LOAD,  16'h0003, 1'b1, 9'd1,   1'b0, '{40'sd0, 9'd0, 1'b0}},
        '{OP_QUERY, 16'h0002, 1'b1, 9'd1,   1'b1, '{40'sd6, 9'd1, 1'b0}}
    };

    stored_vector_dot_product_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] value
        .s_tuser  (s_tuser),    // [0] operation
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [39:0] dot, [48:40] terms
        .m_tuser  (m_tuser)     // [0] truncated
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void predict_dot_request(input op_t op, input logic [15:0] value,
                                                input logic last, input logic given,
                                                input dot_result_t given_result);
        longint      sum;
        dot_result_t res;
        if (op == OP_LOAD) begin
            if (load_pos == 0)
                trunc_mark = 1'b0;
            if (load_pos < MAX_LEN) begin
                ref_mem[load_pos] = value;
                load_pos++;
            end else begin
                trunc_mark = 1'b1;
            end
            if (last) begin
                ref_len  = load_pos;
                load_pos = 0;
            end
            return;
        end
        if (query_pos < ref_len) begin
            sum = dot_acc + longint'($signed(value)) * longint'($signed(ref_mem[query_pos]));
            if (sum > DOT_MAX)
                sum = DOT_MAX;
            if (sum < DOT_MIN)
                sum = DOT_MIN;
            dot_acc = sum;
            query_pos++;
        end
        if (last) begin
            if (ref_len != 0) begin
                res.dot       = dot_acc[DOT_W-1:0];
                res.terms     = query_pos[8:0];
                res.truncated = trunc_mark;
                expected_dots.push_back(given ? given_result : res);
            end
            dot_acc   = 0;
            query_pos = 0;
        end
    endfunction

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [15:0] draw_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int draw_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 12);
        else if (pick < 95)
            return $urandom_range(13, 64);
        else
            return $urandom_range(240, 260);
    endfunction

    // entered at a rising edge; returns at the edge that takes the request
    task automatic send_request(input op_t op, input logic [15:0] value, input logic last,
                                input logic given, input dot_result_t given_result);
        int gap;
        gap = draw_gap(src_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        predict_dot_request(op, value, last, given, given_result);
        sent_requests++;
    endtask

    task automatic send_list(input op_t op, input int len, input bit finish);
        for (int k = 0; k < len; k++)
            send_request(op, draw_value(), finish && (k == len - 1), 1'b0, '0);
    endtask

    // stimulus
    initial begin
        int pick;
        int len;
        int random_start;
        ref_len       = 0;
        load_pos      = 0;
        query_pos     = 0;
        dot_acc       = 0;
        trunc_mark    = 1'b0;
        mismatches    = 0;
        sent_requests = 0;
        hold_wanted   = 1'b0;
        hold_done     = 1'b0;
        src_burst     = 1'b0;
        sink_burst    = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            for (int k = 0; k < dir_rows[i].reps; k++)
                send_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].last,
                             dir_rows[i].given, dir_rows[i].result);

        random_start = sent_requests;
        hold_wanted  = 1'b1;
        while (sent_requests - random_start < RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_list(OP_LOAD, draw_length(), 1'b1);
            end else if (pick < 80) begin
                if ($urandom_range(0, 3) == 0)
                    len = draw_length();
                else
                    len = $urandom_range(1, ref_len + 2);
                send_list(OP_QUERY, len, 1'b1);
            end else if (pick < 90) begin
                // query while a load is still open
                send_list(OP_LOAD, draw_length(), 1'b0);
                send_list(OP_QUERY, $urandom_range(1, ref_len + 2), 1'b1);
                send_list(OP_LOAD, $urandom_range(1, 8), 1'b1);
            end else begin
                send_request(op_t'($urandom_range(0, 1)), draw_value(),
                             $urandom_range(0, 2) == 0, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_dots.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("stored_vector_dot_product_core regression: pass");
        else
            $display("stored_vector_dot_product_core regression: fail");
        $finish;
    end

    // result sink
    initial begin
        int          stall;
        dot_result_t got;
        dot_result_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_wanted && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                stall = draw_gap(sink_burst);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            got.dot       = m_tdata[DOT_W-1:0];
            got.terms     = m_tdata[DOT_W+8:DOT_W];
            got.truncated = m_tuser;
            @(posedge aclk);
            if (expected_dots.size() == 0) begin
                $display("%0t: result with none expected, actual dot %0d terms %0d truncated %0b",
                         $time, got.dot, got.terms, got.truncated);
                mismatches++;
            end else begin
                want = expected_dots.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch, expected dot %0d terms %0d truncated %0b",
                             $time, want.dot, want.terms, want.truncated);
                    $display("%0t:                  actual dot %0d terms %0d truncated %0b",
                             $time, got.dot, got.terms, got.truncated);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles without any request taken on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (aresetn === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, %0d results outstanding", $time, expected_dots.size());
        $display("stored_vector_dot_product_core regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/svdp_pkg.sv
hw/rtl/svdp_ram.sv
hw/rtl/svdp_mac.sv
hw/rtl/stored_vector_dot_product_core.sv
tb/tb_stored_vector_dot_product_core.sv
